// ===== hw/rtl/ghp_pkg.sv =====
// Shared types and constants for the host-pathogen Gillespie step block.
// No dependencies; used by ghp_ctrl, ghp_dp and the top level.
package ghp_pkg;

  localparam int CNT_W   = 16;
  localparam int RATE_W  = 20;
  localparam int TIME_W  = 40;
  localparam int DRAW_W  = 32;
  localparam int TOT_W   = 56;  // sum of six rates, Q.16
  localparam int DVD_W   = 48;  // exp_draw << 16
  localparam int EV_W    = 3;
  localparam int NUM_EV  = 6;
  localparam int CNT_IDX_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 40;

  localparam int POP_LIMIT_DEF = 100;
  localparam int S_START_DEF   = 10;
  localparam int I_START_DEF   = 2;
  localparam int DEATH_RATE_DEF = 655;

  // event codes, in the order the rates are summed
  localparam logic [EV_W-1:0] EV_BIRTH_S   = 3'd0;
  localparam logic [EV_W-1:0] EV_DEATH_S   = 3'd1;
  localparam logic [EV_W-1:0] EV_BIRTH_R   = 3'd2;
  localparam logic [EV_W-1:0] EV_DEATH_R   = 3'd3;
  localparam logic [EV_W-1:0] EV_IMM_PROD  = 3'd4;
  localparam logic [EV_W-1:0] EV_IMM_DECAY = 3'd5;
  localparam logic [EV_W-1:0] EV_NONE = 3'd6;
  localparam logic [CNT_IDX_W-1:0] DIV_LAST = CNT_IDX_W'(DVD_W - 1);
  localparam logic [CNT_IDX_W-1:0] RATE_LAST = CNT_IDX_W'(NUM_EV - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIRTH_S_UNT = 3'd0,
    CFG_BIRTH_R_UNT = 3'd1,
    CFG_BIRTH_S_TRT = 3'd2,
    CFG_BIRTH_R_TRT = 3'd3,
    CFG_TREAT_DUR   = 3'd4,
    CFG_ATTACK      = 3'd5,
    CFG_IMM_PROD    = 3'd6,
    CFG_IMM_DECAY   = 3'd7
  } cfg_idx_t;

  localparam logic [RATE_W-1:0] RST_BIRTH_S = 20'd78633;
  localparam logic [RATE_W-1:0] RST_BIRTH_R = 20'd77332;
  localparam logic [RATE_W-1:0] RST_ATTACK  = 20'd4915;
  localparam logic [RATE_W-1:0] RST_IMM     = 20'd3277;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RESTART, ST_MUL1, ST_MUL2, ST_RATE, ST_ACC, ST_CHK,
    ST_TGT1, ST_TGT2, ST_PICK, ST_DIV, ST_TIME, ST_FIN, ST_PUSH
  } state_t;

  typedef struct packed {
    logic latch;
    logic restart;
    logic mul1;
    logic mul2;
    logic rate;
    logic acc;
    logic zero_done;
    logic tgt1;
    logic tgt2;
    logic pick;
    logic div_step;
    logic time_upd;
    logic fin;
    logic push;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic total_zero;
    logic hit;
  } sts_t;

endpackage

// ===== hw/rtl/ghp_ctrl.sv =====
// Sequencer for the Gillespie step: state machine, step counter, output valid.
// Depends on ghp_pkg.
module ghp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ghp_pkg::sts_t sts,
  output ghp_pkg::cmd_t cmd
);

  ghp_pkg::state_t state_r, state_nxt;
  logic [ghp_pkg::CNT_IDX_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghp_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[2:0];
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ghp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!in_req)      state_nxt = ghp_pkg::ST_RESTART;
          else if (sts.done) state_nxt = ghp_pkg::ST_PUSH;
          else              state_nxt = ghp_pkg::ST_MUL1;
        end
      end
      ghp_pkg::ST_RESTART: begin
        cmd.restart = 1'b1;
        state_nxt = ghp_pkg::ST_FIN;
      end
      ghp_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ghp_pkg::ST_MUL2;
      end
      ghp_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ghp_pkg::ST_RATE;
      end
      ghp_pkg::ST_RATE: begin
        cmd.rate = 1'b1;
        cnt_nxt = '0;
        state_nxt = ghp_pkg::ST_ACC;
      end
      ghp_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ghp_pkg::RATE_LAST) state_nxt = ghp_pkg::ST_CHK;
      end
      ghp_pkg::ST_CHK: begin
        if (sts.total_zero) begin
          cmd.zero_done = 1'b1;
          state_nxt = ghp_pkg::ST_PUSH;
        end else begin
          state_nxt = ghp_pkg::ST_TGT1;
        end
      end
      ghp_pkg::ST_TGT1: begin
        cmd.tgt1 = 1'b1;
        state_nxt = ghp_pkg::ST_TGT2;
      end
      ghp_pkg::ST_TGT2: begin
        cmd.tgt2 = 1'b1;
        cnt_nxt = '0;
        state_nxt = ghp_pkg::ST_PICK;
      end
      ghp_pkg::ST_PICK: begin
        cmd.pick = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (sts.hit || cnt_r == ghp_pkg::RATE_LAST) begin
          cnt_nxt = '0;
          state_nxt = ghp_pkg::ST_DIV;
        end
      end
      ghp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ghp_pkg::DIV_LAST) state_nxt = ghp_pkg::ST_TIME;
      end
      ghp_pkg::ST_TIME: begin
        cmd.time_upd = 1'b1;
        state_nxt = ghp_pkg::ST_FIN;
      end
      ghp_pkg::ST_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = ghp_pkg::ST_PUSH;
      end
      ghp_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ghp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ghp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/ghp_dp.sv =====
// Datapath for the Gillespie step: config registers, run state, rate products,
// cumulative sums, target product, restoring divider and result register.
// Depends on ghp_pkg.
module ghp_dp #(
  parameter int POP_LIMIT      = ghp_pkg::POP_LIMIT_DEF,
  parameter int S_START        = ghp_pkg::S_START_DEF,
  parameter int I_START        = ghp_pkg::I_START_DEF,
  parameter int DEATH_RATE_Q16 = ghp_pkg::DEATH_RATE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ghp_pkg::cmd_t                     cmd,
  output ghp_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [ghp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ghp_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_req,
  input  logic [ghp_pkg::DRAW_W-1:0]        in_uniform,
  input  logic                              in_mut,
  input  logic [ghp_pkg::DRAW_W-1:0]        in_exp,
  output logic [ghp_pkg::CNT_W-1:0]         o_s,
  output logic [ghp_pkg::CNT_W-1:0]         o_r,
  output logic [ghp_pkg::CNT_W-1:0]         o_i,
  output logic [ghp_pkg::EV_W-1:0]          o_ev,
  output logic [ghp_pkg::TIME_W-1:0]        o_time,
  output logic                              o_phase,
  output logic                              o_done,
  output logic                              o_won
);

  localparam int CW = ghp_pkg::CNT_W;
  localparam int RW = ghp_pkg::RATE_W;
  localparam int TW = ghp_pkg::TOT_W;
  localparam int DW = ghp_pkg::DVD_W;
  localparam int XW = ghp_pkg::TIME_W;
  localparam logic [CW-1:0] LIMIT   = CW'(POP_LIMIT);
  localparam logic [CW-1:0] S_INIT  = CW'(S_START);
  localparam logic [CW-1:0] I_INIT  = CW'(I_START);
  localparam logic [RW-1:0] DEATH   = RW'(DEATH_RATE_Q16);
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [XW-1:0] TIME_MAX = '1;

  // configuration
  logic [RW-1:0] bsu_r, bru_r, bst_r, brt_r, atk_r, prod_r, dec_r;
  logic [XW-1:0] dur_r;

  // run state
  logic [CW-1:0] s_r, r_r, i_r;
  logic [XW-1:0] clk_time_r, phase_start_r;
  logic          phase_r, won_r, done_r;

  // item
  logic          req_r, mut_r;
  logic [ghp_pkg::DRAW_W-1:0] u_r, ex_r;
  logic [ghp_pkg::EV_W-1:0]   ev_r;

  // working registers
  logic [TW-1:0] rate_r [ghp_pkg::NUM_EV];
  logic [TW-1:0] cum_r  [ghp_pkg::NUM_EV];
  logic [TW-1:0] acc_r, tgt_r, ks_r, kr_r, ds_r, dr_r;
  logic [RW+CW-1:0] as_r, ar_r;
  logic [TW-1:0]    phi_r;
  logic [63:0]      plo_r;
  logic [TW-1:0]    rem_r;
  logic [DW-1:0]    dvd_r;

  logic [RW-1:0] bs, br;
  logic [CW:0]   sr_sum, tot;
  logic [TW-1:0] acc_nxt;
  logic [TW:0]   rem_sh, rem_sub;
  logic [DW:0]   time_sum;
  logic [XW-1:0] elapsed;

  assign bs      = phase_r ? bst_r : bsu_r;
  assign br      = phase_r ? brt_r : bru_r;
  assign sr_sum  = {1'b0, s_r} + {1'b0, r_r};
  assign tot     = sr_sum;
  assign acc_nxt = acc_r + rate_r[cmd.idx];
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, acc_r};
  assign time_sum = {{(DW-XW){1'b0}}, 1'b0, clk_time_r} + {1'b0, dvd_r};
  assign elapsed  = clk_time_r - phase_start_r;

  assign sts.done       = done_r;
  assign sts.total_zero = (acc_r == '0);
  assign sts.hit        = (tgt_r < cum_r[cmd.idx]);

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // configuration and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsu_r <= ghp_pkg::RST_BIRTH_S;
      bru_r <= ghp_pkg::RST_BIRTH_R;
      bst_r <= ghp_pkg::RST_BIRTH_S;
      brt_r <= ghp_pkg::RST_BIRTH_R;
      dur_r <= '0;
      atk_r <= ghp_pkg::RST_ATTACK;
      prod_r <= ghp_pkg::RST_IMM;
      dec_r <= ghp_pkg::RST_IMM;
      s_r <= S_INIT;
      r_r <= '0;
      i_r <= I_INIT;
      clk_time_r <= '0;
      won_r <= 1'b0;
      done_r <= 1'b0;
      // initial counts may already meet the switch condition
      phase_r <= (S_INIT >= LIMIT);
      phase_start_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (ghp_pkg::cfg_idx_t'(cfg_index))
          ghp_pkg::CFG_BIRTH_S_UNT: bsu_r  <= cfg_data[RW-1:0];
          ghp_pkg::CFG_BIRTH_R_UNT: bru_r  <= cfg_data[RW-1:0];
          ghp_pkg::CFG_BIRTH_S_TRT: bst_r  <= cfg_data[RW-1:0];
          ghp_pkg::CFG_BIRTH_R_TRT: brt_r  <= cfg_data[RW-1:0];
          ghp_pkg::CFG_TREAT_DUR:   dur_r  <= cfg_data[XW-1:0];
          ghp_pkg::CFG_ATTACK:      atk_r  <= cfg_data[RW-1:0];
          ghp_pkg::CFG_IMM_PROD:    prod_r <= cfg_data[RW-1:0];
          ghp_pkg::CFG_IMM_DECAY:   dec_r  <= cfg_data[RW-1:0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        s_r <= S_INIT;
        r_r <= '0;
        i_r <= I_INIT;
        clk_time_r <= '0;
        phase_start_r <= '0;
        phase_r <= 1'b0;
        won_r <= 1'b0;
        done_r <= 1'b0;
      end
      if (cmd.zero_done) done_r <= 1'b1;
      if (cmd.time_upd) begin
        case (ev_r)
          ghp_pkg::EV_BIRTH_S:
            if (mut_r) r_r <= inc_sat(r_r); else s_r <= inc_sat(s_r);
          ghp_pkg::EV_DEATH_S:   s_r <= dec_sat(s_r);
          ghp_pkg::EV_BIRTH_R:   r_r <= inc_sat(r_r);
          ghp_pkg::EV_DEATH_R:   r_r <= dec_sat(r_r);
          ghp_pkg::EV_IMM_PROD:  i_r <= inc_sat(i_r);
          ghp_pkg::EV_IMM_DECAY: i_r <= dec_sat(i_r);
          default: ;
        endcase
        clk_time_r <= (time_sum[DW:XW] != '0) ? TIME_MAX : time_sum[XW-1:0];
      end
      if (cmd.fin) begin
        if (req_r && r_r >= LIMIT) won_r <= 1'b1;
        if (!phase_r) begin
          if (tot == '0 || tot >= {1'b0, LIMIT}) begin
            phase_r <= 1'b1;
            phase_start_r <= clk_time_r;
          end
        end else if (req_r && elapsed > dur_r) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // item and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
      mut_r <= in_mut;
      u_r   <= in_uniform;
      ex_r  <= in_exp;
      ev_r  <= ghp_pkg::EV_NONE;
    end
    if (cmd.mul1) begin
      rate_r[0] <= TW'(bs * s_r);
      rate_r[2] <= TW'(br * r_r);
      ds_r <= TW'(DEATH * s_r);
      dr_r <= TW'(DEATH * r_r);
      as_r <= atk_r * s_r;
      ar_r <= atk_r * r_r;
      rate_r[4] <= TW'(prod_r * sr_sum);
      rate_r[5] <= TW'(dec_r * i_r);
    end
    if (cmd.mul2) begin
      ks_r <= TW'(as_r * i_r);
      kr_r <= TW'(ar_r * i_r);
    end
    if (cmd.rate) begin
      rate_r[1] <= ds_r + ks_r;
      rate_r[3] <= dr_r + kr_r;
      acc_r <= '0;
    end
    if (cmd.acc) begin
      acc_r <= acc_nxt;
      cum_r[cmd.idx] <= acc_nxt;
    end
    if (cmd.tgt1) begin
      phi_r <= TW'(u_r * acc_r[TW-1:32]);
      plo_r <= u_r * acc_r[31:0];
      rem_r <= '0;
      dvd_r <= {ex_r, 16'd0};
    end
    if (cmd.tgt2) tgt_r <= phi_r + {{(TW-32){1'b0}}, plo_r[63:32]};
    if (cmd.pick && sts.hit) ev_r <= cmd.idx;
    if (cmd.div_step) begin
      if (!rem_sub[TW]) begin
        rem_r <= rem_sub[TW-1:0];
        dvd_r <= {dvd_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[TW-1:0];
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.push) begin
      o_s <= s_r;
      o_r <= r_r;
      o_i <= i_r;
      o_ev <= ev_r;
      o_time <= clk_time_r;
      o_phase <= phase_r;
      o_done <= done_r;
      o_won <= won_r;
    end
  end

endmodule

// ===== hw/rtl/gillespie_host_pathogen_step.sv =====
// Gillespie direct-method step, host-pathogen model with S, R and immune counts.
// Event step: accept, products, rates, accumulate, target, pick (rates in order until one
// hits or the last is reached), divide, time update, finish, push; the restoring divider
// for the time step sets the pace. Restart: restart, finish, push; a request after the run
// has ended: push only. One item at a time: in_tready returns the cycle after the result
// is loaded, and a held result stalls the next load.
// Synchronous active-low reset: config registers to their reset values, counts to the
// initial values, time, won and done cleared, phase set if S_START reaches POP_LIMIT, no result pending.
module gillespie_host_pathogen_step #(
  parameter int POP_LIMIT      = ghp_pkg::POP_LIMIT_DEF,
  parameter int S_START        = ghp_pkg::S_START_DEF,
  parameter int I_START        = ghp_pkg::I_START_DEF,
  parameter int DEATH_RATE_Q16 = ghp_pkg::DEATH_RATE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // uniform_draw[31:0], mutation_draw[32], exp_draw[64:33]
  input  logic        in_tuser,   // req_type
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // sensitive[15:0], resistant[31:16], immune[47:32],
                                  // event_chosen[50:48], sim_time[90:51],
                                  // treated_phase[91], run_done[92], resistant_won[93]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ghp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghp_pkg::CFG_W-1:0]     cfg_data
);

  ghp_pkg::cmd_t cmd;
  ghp_pkg::sts_t sts;

  logic [ghp_pkg::CNT_W-1:0]  o_s, o_r, o_i;
  logic [ghp_pkg::EV_W-1:0]   o_ev;
  logic [ghp_pkg::TIME_W-1:0] o_time;
  logic o_phase, o_done, o_won;

  // registers are always writable; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  ghp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ghp_dp #(
    .POP_LIMIT      (POP_LIMIT),
    .S_START        (S_START),
    .I_START        (I_START),
    .DEATH_RATE_Q16 (DEATH_RATE_Q16)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_req     (in_tuser),
    .in_uniform (in_tdata[31:0]),
    .in_mut     (in_tdata[32]),
    .in_exp     (in_tdata[64:33]),
    .o_s        (o_s),
    .o_r        (o_r),
    .o_i        (o_i),
    .o_ev       (o_ev),
    .o_time     (o_time),
    .o_phase    (o_phase),
    .o_done     (o_done),
    .o_won      (o_won)
  );

  assign out_tdata = {2'b00, o_won, o_done, o_phase, o_time, o_ev, o_i, o_r, o_s};

endmodule
